// ----- src/dsgd_pkg.sv -----
// Shared types and constants for the drag shake detector.
// Used by dsgd_scan and drag_shake_gesture_detector_core; no dependencies.
package dsgd_pkg;

    localparam int HISTORY_DEPTH_DEF = 128;

    localparam int TIME_W   = 32;
    localparam int POS_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 48;
    localparam int CMP_W    = 64;

    localparam int SPEED_SCALE = 1000;
    localparam int RATE_SCALE  = 1000000;

    localparam logic KIND_MOVE    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [7:0]  MIN_ENTRIES_RST   = 8'd6;
    localparam logic [6:0]  MIN_REVERSALS_RST = 7'd4;
    localparam logic [15:0] WINDOW_MS_RST     = 16'd800;
    localparam logic [15:0] MIN_SPAN_MS_RST   = 16'd50;
    localparam logic [15:0] MAX_NET_MOVE_RST  = 16'd1000;
    localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd2000;
    localparam logic [15:0] SPEED_THR_RST     = 16'd180;
    localparam logic [15:0] MIN_RATE_MHZ_RST  = 16'd1800;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ENTRIES   = 3'd0,
        CFG_MIN_REVERSALS = 3'd1,
        CFG_WINDOW_MS     = 3'd2,
        CFG_MIN_SPAN_MS   = 3'd3,
        CFG_MAX_NET_MOVE  = 3'd4,
        CFG_DEBOUNCE_MS   = 3'd5,
        CFG_SPEED_THR     = 3'd6,
        CFG_MIN_RATE_MHZ  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_PRUNE_RD,
        ST_PRUNE_CK,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_SPAN,
        ST_MAVG,
        ST_MRATE,
        ST_RCHK,
        ST_DEC
    } t_state;

    typedef enum logic [1:0] {
        MUL_STEP,
        MUL_AVG,
        MUL_RATE
    } t_mul_sel;

    typedef struct packed {
        logic     clr;
        logic     rd_valid;
        logic     rd_first;
        logic     span_ld;
        logic     avg_ld;
        logic     rate_ld;
        t_mul_sel mul_sel;
    } t_scan_ctl;

    typedef struct packed {
        logic busy;
        logic peak_ok;
        logic avg_ok;
        logic rate_ok;
    } t_scan_sts;

endpackage

// ----- src/dsgd_scan.sv -----
// History scan datapath: step differences, shared 16x32 multiplier, reversal
// and speed accumulation, span and net travel. Depends on dsgd_pkg.
module dsgd_scan #(
    parameter int HISTORY_DEPTH = dsgd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dsgd_pkg::t_scan_ctl                 i_ctl,
    input  logic [dsgd_pkg::TIME_W-1:0]         i_rd_time,
    input  logic [dsgd_pkg::POS_W-1:0]          i_rd_x,
    input  logic [dsgd_pkg::CFG_W-1:0]          i_thr,
    input  logic [dsgd_pkg::CFG_W-1:0]          i_mhz,
    output dsgd_pkg::t_scan_sts                 o_sts,
    output logic [$clog2(HISTORY_DEPTH)-1:0]    o_rev,
    output logic [dsgd_pkg::TIME_W-1:0]         o_span,
    output logic [dsgd_pkg::POS_W-1:0]          o_net
);
    import dsgd_pkg::*;

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int REV_W  = ADDR_W;
    localparam int SUM_W  = ADDR_W + POS_W;
    localparam int ADX1K_W = POS_W + 10;

    logic [TIME_W-1:0]  r_first_t, r_prev_t, r_dt, r_span;
    logic [POS_W-1:0]   r_first_x, r_prev_x, r_net;
    logic [POS_W:0]     r_dx;
    logic               r_v2, r_v3;
    logic [PROD_W-1:0]  r_prod;
    logic [POS_W-1:0]   r_adx;
    logic [ADX1K_W-1:0] r_adx1k;
    logic               r_neg, r_dtz;
    logic [SUM_W-1:0]   r_sum;
    logic [REV_W-1:0]   r_rev;
    logic               r_peak, r_ps_valid, r_ps_neg;
    logic               r_avg_ok, r_rate_ok;

    logic [CFG_W-1:0]   mul_a;
    logic [TIME_W-1:0]  mul_b;
    logic [POS_W:0]     dx_abs_full;
    logic [POS_W:0]     net_diff;
    logic [PROD_W-1:0]  adx1k_ext;

    always_comb begin
        unique case (i_ctl.mul_sel)
            MUL_STEP: begin
                mul_a = i_thr;
                mul_b = r_dt;
            end
            MUL_AVG: begin
                mul_a = i_thr;
                mul_b = r_span;
            end
            MUL_RATE: begin
                mul_a = i_mhz;
                mul_b = r_span;
            end
            default: begin
                mul_a = i_thr;
                mul_b = r_dt;
            end
        endcase
    end

    assign dx_abs_full = r_dx[POS_W] ? (~r_dx + (POS_W+1)'(1)) : r_dx;
    assign net_diff    = {r_prev_x[POS_W-1], r_prev_x} - {r_first_x[POS_W-1], r_first_x};
    assign adx1k_ext   = PROD_W'(r_adx1k);

    // read stage: previous entry and step differences
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_valid) begin
            if (i_ctl.rd_first) begin
                r_first_t <= i_rd_time;
                r_first_x <= i_rd_x;
            end else begin
                r_dt <= i_rd_time - r_prev_t;
                r_dx <= {i_rd_x[POS_W-1], i_rd_x} - {r_prev_x[POS_W-1], r_prev_x};
            end
            r_prev_t <= i_rd_time;
            r_prev_x <= i_rd_x;
        end
        r_prod  <= PROD_W'(mul_a) * PROD_W'(mul_b);
        r_adx   <= dx_abs_full[POS_W-1:0];
        r_adx1k <= ADX1K_W'(dx_abs_full[POS_W-1:0]) * ADX1K_W'(SPEED_SCALE);
        r_neg   <= r_dx[POS_W];
        r_dtz   <= (r_dt == '0);
        if (i_ctl.span_ld) begin
            r_span <= r_prev_t - r_first_t;
            r_net  <= net_diff[POS_W] ? POS_W'(~net_diff + (POS_W+1)'(1))
                                      : net_diff[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.rd_valid && !i_ctl.rd_first;
            r_v3 <= r_v2;
        end
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_sum      <= '0;
            r_rev      <= '0;
            r_peak     <= 1'b0;
            r_ps_valid <= 1'b0;
            r_ps_neg   <= 1'b0;
        end else if (r_v3 && !r_dtz) begin
            r_sum <= r_sum + SUM_W'(r_adx);
            if (adx1k_ext >= r_prod) begin
                r_peak <= 1'b1;
            end
            if (adx1k_ext > r_prod) begin
                if (!r_ps_valid) begin
                    r_ps_valid <= 1'b1;
                    r_ps_neg   <= r_neg;
                end else if (r_ps_neg != r_neg) begin
                    r_rev    <= r_rev + REV_W'(1);
                    r_ps_neg <= r_neg;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.avg_ld) begin
            r_avg_ok <= (r_span == '0) ? (i_thr == '0)
                      : (CMP_W'(r_sum) * CMP_W'(SPEED_SCALE) >= CMP_W'(r_prod));
        end
        if (i_ctl.rate_ld) begin
            r_rate_ok <= (r_span == '0) ? (i_mhz == '0)
                       : (CMP_W'(r_rev) * CMP_W'(RATE_SCALE) >= CMP_W'(r_prod));
        end
    end

    assign o_sts = '{busy: r_v2 || r_v3, peak_ok: r_peak,
                     avg_ok: r_avg_ok, rate_ok: r_rate_ok};
    assign o_rev  = r_rev;
    assign o_span = r_span;
    assign o_net  = r_net;

endmodule

// ----- src/drag_shake_gesture_detector_core.sv -----
// Drag shake detector top level: history memory, control sequencer, output item.
// Depends on dsgd_pkg and dsgd_scan.
// Sequence: a move is pushed into the history and entries older than the window are pruned;
// then the entries are scanned unless too few are held; a stalled output holds the decision.
// Throughput: one item at a time, next input taken the cycle after the result registers.
// Reset (synchronous, active low) empties the history; store contents stay.
module drag_shake_gesture_detector_core #(
    parameter int HISTORY_DEPTH = dsgd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [47:0]                          s_axis_tdata,  // time_ms[31:0], pos_x[47:32]
    input  logic                                 s_axis_tuser,  // kind
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [15:0]                          m_axis_tdata,  // shake_detected[0],
                                                                // reversal_count[7:1],
                                                                // samples_held[15:8]
    input  logic                                 i_cfg_we,
    input  logic [dsgd_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [dsgd_pkg::CFG_W-1:0]           i_cfg_wdata
);
    import dsgd_pkg::*;

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int REV_W  = ADDR_W;
    localparam int ENT_W  = TIME_W + POS_W;
    localparam logic [CNT_W-1:0] DEPTH_V = CNT_W'(HISTORY_DEPTH);

    function automatic logic [ADDR_W-1:0] wrap(input logic [ADDR_W:0] s);
        logic [ADDR_W:0] t;
        t = (s >= DEPTH_V) ? (s - DEPTH_V) : s;
        return t[ADDR_W-1:0];
    endfunction

    // configuration
    logic [7:0]       r_min_entries;
    logic [6:0]       r_min_rev;
    logic [CFG_W-1:0] r_window, r_min_span, r_max_net, r_debounce, r_thr, r_mhz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_entries <= MIN_ENTRIES_RST;
            r_min_rev     <= MIN_REVERSALS_RST;
            r_window      <= WINDOW_MS_RST;
            r_min_span    <= MIN_SPAN_MS_RST;
            r_max_net     <= MAX_NET_MOVE_RST;
            r_debounce    <= DEBOUNCE_MS_RST;
            r_thr         <= SPEED_THR_RST;
            r_mhz         <= MIN_RATE_MHZ_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MIN_ENTRIES:   r_min_entries <= i_cfg_wdata[7:0];
                CFG_MIN_REVERSALS: r_min_rev     <= i_cfg_wdata[6:0];
                CFG_WINDOW_MS:     r_window      <= i_cfg_wdata;
                CFG_MIN_SPAN_MS:   r_min_span    <= i_cfg_wdata;
                CFG_MAX_NET_MOVE:  r_max_net     <= i_cfg_wdata;
                CFG_DEBOUNCE_MS:   r_debounce    <= i_cfg_wdata;
                CFG_SPEED_THR:     r_thr         <= i_cfg_wdata;
                CFG_MIN_RATE_MHZ:  r_mhz         <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_oldest, n_oldest;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [TIME_W-1:0]  r_last_shake, n_last_shake;
    logic [TIME_W-1:0]  r_now, n_now;
    logic [POS_W-1:0]   r_x, n_x;
    logic               r_rv, n_rv;
    logic               r_rfirst, n_rfirst;
    logic               r_skip, n_skip;
    logic               r_out_valid, n_out_valid;
    logic [15:0]        r_out_data, n_out_data;

    // history memory
    logic [ENT_W-1:0]   mem [HISTORY_DEPTH];
    logic [ENT_W-1:0]   r_rd;
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= {r_now, r_x};
        end
        r_rd <= mem[rd_addr];
    end

    // scan datapath
    t_scan_ctl          scan_ctl;
    t_scan_sts          scan_sts;
    logic [REV_W-1:0]   scan_rev;
    logic [TIME_W-1:0]  scan_span;
    logic [POS_W-1:0]   scan_net;

    dsgd_scan #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_rd_time (r_rd[ENT_W-1:POS_W]),
        .i_rd_x    (r_rd[POS_W-1:0]),
        .i_thr     (r_thr),
        .i_mhz     (r_mhz),
        .o_sts     (scan_sts),
        .o_rev     (scan_rev),
        .o_span    (scan_span),
        .o_net     (scan_net)
    );

    // decision
    logic              scan_ok, shake;
    logic [6:0]        rev_out;
    logic [CNT_W-1:0]  held;
    logic [7:0]        held_out;
    logic [TIME_W-1:0] prune_age;

    assign scan_ok = !r_skip && (scan_span >= TIME_W'(r_min_span));
    assign shake   = scan_ok && (scan_net <= r_max_net)
                     && (16'(scan_rev) >= 16'(r_min_rev))
                     && (scan_sts.avg_ok || scan_sts.peak_ok) && scan_sts.rate_ok
                     && ((r_now - r_last_shake) >= TIME_W'(r_debounce));
    assign rev_out  = !scan_ok ? 7'd0
                    : (16'(scan_rev) > 16'd127) ? 7'd127 : 7'(scan_rev);
    assign held     = shake ? '0 : r_count;
    assign held_out = (16'(held) > 16'd255) ? 8'd255 : 8'(held);
    assign prune_age = r_now - r_rd[ENT_W-1:POS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_oldest     <= '0;
            r_last_shake <= '0;
            r_rv         <= 1'b0;
            r_rfirst     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_oldest     <= n_oldest;
            r_last_shake <= n_last_shake;
            r_rv         <= n_rv;
            r_rfirst     <= n_rfirst;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_now      <= n_now;
        r_x        <= n_x;
        r_skip     <= n_skip;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_oldest     = r_oldest;
        n_idx        = r_idx;
        n_last_shake = r_last_shake;
        n_now        = r_now;
        n_x          = r_x;
        n_skip       = r_skip;
        n_rv         = 1'b0;
        n_rfirst     = 1'b0;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        mem_we       = 1'b0;
        wr_addr      = wrap({1'b0, r_oldest} + r_count);
        rd_addr      = r_oldest;
        scan_ctl     = '{clr: 1'b0, rd_valid: r_rv, rd_first: r_rfirst, span_ld: 1'b0,
                         avg_ld: 1'b0, rate_ld: 1'b0, mul_sel: MUL_STEP};

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_now   = s_axis_tdata[TIME_W-1:0];
                    n_x     = s_axis_tdata[ENT_W-1:TIME_W];
                    n_state = (s_axis_tuser == KIND_MOVE) ? ST_PUSH : ST_CHECK;
                end
            end
            ST_PUSH: begin
                mem_we = 1'b1;
                if (r_count == DEPTH_V) begin
                    wr_addr  = r_oldest;
                    n_oldest = wrap({1'b0, r_oldest} + CNT_W'(1));
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = ST_PRUNE_RD;
            end
            ST_PRUNE_RD: begin
                n_state = ST_PRUNE_CK;
            end
            ST_PRUNE_CK: begin
                if (r_count != '0 && prune_age > TIME_W'(r_window)) begin
                    n_oldest = wrap({1'b0, r_oldest} + CNT_W'(1));
                    n_count  = r_count - CNT_W'(1);
                    n_state  = ST_PRUNE_RD;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                scan_ctl.clr = 1'b1;
                n_idx        = '0;
                if (r_count == '0 || 16'(r_count) < 16'(r_min_entries)) begin
                    n_skip  = 1'b1;
                    n_state = ST_DEC;
                end else begin
                    n_skip  = 1'b0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_addr  = wrap({1'b0, r_oldest} + {1'b0, r_idx});
                n_rv     = 1'b1;
                n_rfirst = (r_idx == '0);
                n_idx    = r_idx + ADDR_W'(1);
                if ({1'b0, r_idx} == r_count - CNT_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rv && !scan_sts.busy) begin
                    n_state = ST_SPAN;
                end
            end
            ST_SPAN: begin
                scan_ctl.span_ld = 1'b1;
                n_state          = ST_MAVG;
            end
            ST_MAVG: begin
                scan_ctl.mul_sel = MUL_AVG;
                n_state          = ST_MRATE;
            end
            ST_MRATE: begin
                scan_ctl.mul_sel = MUL_RATE;
                scan_ctl.avg_ld  = 1'b1;
                n_state          = ST_RCHK;
            end
            ST_RCHK: begin
                scan_ctl.rate_ld = 1'b1;
                n_state          = ST_DEC;
            end
            ST_DEC: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {held_out, rev_out, shake};
                    if (shake) begin
                        n_last_shake = r_now;
                        n_count      = '0;
                        n_oldest     = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_V)
        else $error("history count above depth");

    a_move_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_MOVE) |=> r_state == ST_PUSH)
        else $error("move item did not reach push");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_count != '0 && !r_skip))
        else $error("scan on empty history");

    a_shake_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEC && n_state == ST_IDLE && shake) |=> (r_count == '0))
        else $error("shake did not clear history");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for drag_shake_gesture_detector_core: directed and random
// drag/release items, predicted results compared field by field. Depends on dsgd_pkg.
module tb_top;
    import dsgd_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH_DEF;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] x;
        logic [31:0]        ms;
    } drag_item_t;

    typedef struct packed {
        logic [7:0] held;
        logic [6:0] revs;
        logic       shake;
    } shake_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    drag_shake_gesture_detector_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [31:0]        hist_ms [DEPTH];
    logic signed [15:0] hist_x  [DEPTH];
    int                 head_slot = 0;
    int                 held_n = 0;
    logic [31:0]        last_shake_ms = '0;

    logic [7:0]  cfg_min_entries = MIN_ENTRIES_RST;
    logic [6:0]  cfg_min_revs    = MIN_REVERSALS_RST;
    logic [15:0] cfg_window      = WINDOW_MS_RST;
    logic [15:0] cfg_min_span    = MIN_SPAN_MS_RST;
    logic [15:0] cfg_max_net     = MAX_NET_MOVE_RST;
    logic [15:0] cfg_debounce    = DEBOUNCE_MS_RST;
    logic [15:0] cfg_speed_thr   = SPEED_THR_RST;
    logic [15:0] cfg_min_rate    = MIN_RATE_MHZ_RST;

    drag_item_t    pending_q [$];
    shake_result_t shake_exp_q [$];
    drag_item_t    drv_item;
    shake_result_t rx_got, rx_want;

    int errors = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int results_seen = 0;
    int hold_left = 0;

    logic [31:0]        tb_t = '0;
    logic signed [15:0] tb_x = '0;

    function automatic int slot_at(int i);
        return (head_slot + i) % DEPTH;
    endfunction

    function automatic shake_result_t predict_gesture(drag_item_t it);
        shake_result_t r;
        logic [31:0]   span, dt, age;
        int unsigned   revs, sum_abs, adx, net;
        int            dx, i, a, b, sgn, prev_sgn;
        longint        lhs, rhs;
        logic          peak_ok, avg_ok, rate_ok;
        revs = 0;
        sum_abs = 0;
        prev_sgn = 0;
        peak_ok = 1'b0;
        r = '0;
        if (it.kind == KIND_MOVE) begin
            if (held_n >= DEPTH) begin
                head_slot = (head_slot + 1) % DEPTH;
                held_n--;
            end
            hist_ms[slot_at(held_n)] = it.ms;
            hist_x[slot_at(held_n)] = it.x;
            held_n++;
            age = it.ms - hist_ms[slot_at(0)];
            while (held_n > 0 && age > cfg_window) begin
                head_slot = (head_slot + 1) % DEPTH;
                held_n--;
                age = it.ms - hist_ms[slot_at(0)];
            end
        end
        if (held_n != 0 && held_n >= cfg_min_entries) begin
            span = hist_ms[slot_at(held_n - 1)] - hist_ms[slot_at(0)];
            if (span >= cfg_min_span) begin
                for (i = 1; i < held_n; i++) begin
                    a = slot_at(i - 1);
                    b = slot_at(i);
                    dt = hist_ms[b] - hist_ms[a];
                    if (dt != 0) begin
                        dx = int'(hist_x[b]) - int'(hist_x[a]);
                        adx = (dx < 0) ? -dx : dx;
                        sum_abs += adx;
                        rhs = longint'(cfg_speed_thr) * longint'(dt);
                        if (longint'(adx) * 1000 >= rhs)
                            peak_ok = 1'b1;
                        lhs = longint'(dx) * 1000;
                        if (lhs > rhs)
                            sgn = 1;
                        else if (lhs < -rhs)
                            sgn = -1;
                        else
                            sgn = 0;
                        if (sgn != 0) begin
                            if (prev_sgn == 0) begin
                                prev_sgn = sgn;
                            end else if (sgn != prev_sgn) begin
                                revs++;
                                prev_sgn = sgn;
                            end
                        end
                    end
                end
                if (span == 0) begin
                    avg_ok = (cfg_speed_thr == 0);
                    rate_ok = (cfg_min_rate == 0);
                end else begin
                    avg_ok = longint'(sum_abs) * 1000 >=
                             longint'(cfg_speed_thr) * longint'(span);
                    rate_ok = longint'(revs) * 1000000 >=
                              longint'(cfg_min_rate) * longint'(span);
                end
                dx = int'(hist_x[slot_at(held_n - 1)]) - int'(hist_x[slot_at(0)]);
                net = (dx < 0) ? -dx : dx;
                age = it.ms - last_shake_ms;
                if (net <= cfg_max_net && revs >= cfg_min_revs && (avg_ok || peak_ok) &&
                    rate_ok && age >= cfg_debounce) begin
                    last_shake_ms = it.ms;
                    held_n = 0;
                    head_slot = 0;
                    r.shake = 1'b1;
                end
            end
        end
        r.revs = (revs > 127) ? 7'd127 : revs[6:0];
        r.held = (held_n > 255) ? 8'd255 : held_n[7:0];
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                shake_exp_q.insert(shake_exp_q.size(), predict_gesture(drv_item));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    drv_item = pending_q[0];
                    pending_q.delete(0);
                    s_axis_tdata <= {drv_item.x, drv_item.ms};
                    s_axis_tuser <= drv_item.kind;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side flow control
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_got = m_axis_tdata;
            if (shake_exp_q.size() == 0) begin
                $display("%0t: result expected none actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                rx_want = shake_exp_q[0];
                shake_exp_q.delete(0);
                check_field("shake_detected", rx_want.shake, rx_got.shake);
                check_field("reversal_count", rx_want.revs, rx_got.revs);
                check_field("samples_held", rx_want.held, rx_got.held);
            end
            results_seen++;
            if (results_seen == 250 || results_seen == 1000)
                hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic void queue_item(logic kind, logic [31:0] ms, logic [15:0] x);
        drag_item_t it;
        it.kind = kind;
        it.ms = ms;
        it.x = x;
        pending_q.insert(pending_q.size(), it);
    endfunction

    // oscillating drag; sometimes with drift so net travel gets large
    function automatic void gen_shake_burst();
        int n, amp, drift, dir, left, i, jit;
        n = $urandom_range(5, 24);
        amp = $urandom_range(2, 160);
        drift = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 400)) - 200 : 0;
        dir = 1;
        left = $urandom_range(1, 2);
        for (i = 0; i < n; i++) begin
            jit = int'($urandom_range(0, 20)) - 10;
            tb_t = tb_t + $urandom_range(0, 45);
            tb_x = tb_x + 16'(amp * dir + jit + drift);
            queue_item(KIND_MOVE, tb_t, tb_x);
            if ($urandom_range(0, 5) == 0)
                queue_item(KIND_RELEASE, tb_t, 16'($urandom));
            left--;
            if (left == 0) begin
                dir = -dir;
                left = $urandom_range(1, 2);
            end
        end
        if ($urandom_range(0, 1) == 0)
            queue_item(KIND_RELEASE, tb_t + $urandom_range(0, 30), tb_x);
        tb_t = tb_t + $urandom_range(0, 2500);
    endfunction

    function automatic void gen_noise();
        int n, i;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: tb_t = tb_t + $urandom_range(0, 5);
                1: tb_t = tb_t - $urandom_range(1, 100);
                2: tb_t = $urandom;
                default: tb_t = tb_t + $urandom_range(1000, 70000);
            endcase
            tb_x = 16'($urandom);
            queue_item(logic'($urandom_range(0, 1)), tb_t, tb_x);
        end
    endfunction

    function automatic void gen_equal_ticks();
        int n, i;
        n = $urandom_range(2, 8);
        for (i = 0; i < n; i++) begin
            tb_x = tb_x + 16'(int'($urandom_range(0, 600)) - 300);
            queue_item(KIND_MOVE, tb_t, tb_x);
        end
        tb_t = tb_t + $urandom_range(1, 50);
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_MIN_ENTRIES:   cfg_min_entries = val[7:0];
            CFG_MIN_REVERSALS: cfg_min_revs = val[6:0];
            CFG_WINDOW_MS:     cfg_window = val;
            CFG_MIN_SPAN_MS:   cfg_min_span = val;
            CFG_MAX_NET_MOVE:  cfg_max_net = val;
            CFG_DEBOUNCE_MS:   cfg_debounce = val;
            CFG_SPEED_THR:     cfg_speed_thr = val;
            CFG_MIN_RATE_MHZ:  cfg_min_rate = val;
            default: ;
        endcase
    endtask

    // 0 reset values, 1 low extremes, 2 high extremes, 3 permissive, else random
    task automatic apply_setting(int s);
        logic [15:0] ms, mr, win, span, net, deb, thr, rate;
        case (s)
            0: begin
                ms = MIN_ENTRIES_RST; mr = MIN_REVERSALS_RST; win = WINDOW_MS_RST;
                span = MIN_SPAN_MS_RST; net = MAX_NET_MOVE_RST; deb = DEBOUNCE_MS_RST;
                thr = SPEED_THR_RST; rate = MIN_RATE_MHZ_RST;
            end
            1: begin
                ms = 2; mr = 1; win = 1; span = 0; net = 0; deb = 0; thr = 1; rate = 0;
            end
            2: begin
                ms = 128; mr = 127; win = 16'hFFFF; span = 16'hFFFF; net = 16'hFFFF;
                deb = 16'hFFFF; thr = 16'hFFFF; rate = 16'hFFFF;
            end
            3: begin
                ms = 2; mr = 1; win = 2000; span = 0; net = 16'hFFFF; deb = 0;
                thr = 50; rate = 0;
            end
            default: begin
                ms = $urandom_range(2, 16); mr = $urandom_range(1, 6);
                win = $urandom_range(200, 5000); span = $urandom_range(0, 300);
                net = $urandom_range(0, 3000); deb = $urandom_range(0, 3000);
                thr = $urandom_range(1, 2000); rate = $urandom_range(0, 5000);
            end
        endcase
        write_reg(CFG_MIN_ENTRIES, ms);
        write_reg(CFG_MIN_REVERSALS, mr);
        write_reg(CFG_WINDOW_MS, win);
        write_reg(CFG_MIN_SPAN_MS, span);
        write_reg(CFG_MAX_NET_MOVE, net);
        write_reg(CFG_DEBOUNCE_MS, deb);
        write_reg(CFG_SPEED_THR, thr);
        write_reg(CFG_MIN_RATE_MHZ, rate);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_axis_tvalid || shake_exp_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        int schedule [12];
        int p, i, pick;
        logic signed [15:0] xs;
        schedule = '{3, 2, 4, 1, 0, 4, 3, 2, 4, 1, 4, 3};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty release, extreme fields, equal ticks, wrap, shake,
        // debounce hold-off, net travel too large
        queue_item(KIND_RELEASE, 32'd0, 16'd0);
        queue_item(KIND_MOVE, 32'd0, 16'h8000);
        queue_item(KIND_MOVE, 32'd0, 16'h7FFF);
        queue_item(KIND_RELEASE, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(KIND_MOVE, 32'hFFFF_FFF0, 16'd0);
        for (i = 0; i < 6; i++)
            queue_item(KIND_MOVE, 32'd3000 + 20 * i, (i % 2) ? 16'd100 : 16'd0);
        for (i = 0; i < 7; i++)
            queue_item(KIND_MOVE, 32'd3120 + 20 * i, (i % 2) ? 16'd0 : 16'd100);
        queue_item(KIND_RELEASE, 32'd3300, 16'd0);
        xs = 0;
        for (i = 0; i < 7; i++) begin
            if (i != 0)
                xs = xs + ((i % 2) ? 16'sd500 : -16'sd100);
            queue_item(KIND_MOVE, 32'd9000 + 20 * i, xs);
        end
        wait_drained();
        tb_t = 32'd20000;

        for (p = 0; p < 12; p++) begin
            apply_setting(schedule[p]);
            case (p % 3)
                0: begin tx_idle_pct = 35; rx_stall_pct = 67; end
                1: begin tx_idle_pct = 67; rx_stall_pct = 35; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            while (pending_q.size() < 143) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    gen_shake_burst();
                end else if (pick < 78) begin
                    gen_noise();
                end else if (pick < 90) begin
                    gen_equal_ticks();
                end else begin
                    tb_t = 32'hFFFF_FFFF - $urandom_range(0, 400);
                    gen_shake_burst();
                end
            end
            wait_drained();
        end

        repeat (500) @(posedge i_clk);
        if (errors == 0 && shake_exp_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
